// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/htwi_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex text parser package
// Types, constants and helpers shared by the parser and its interfaces.
// ----------------------------------------------------------------------------
package htwi_pkg;

  localparam int WordBits     = 64;
  localparam int CharW        = 8;
  localparam int CfgW         = 3;
  localparam int WordIdxW     = 2;
  localparam int MaxWordsDef  = 4;
  localparam int DigitsPerWord = WordBits / 4;

  localparam logic [CfgW-1:0] WordsInUseRst = 3'd4;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO1,
    PH_LEAD,
    PH_DIGITS
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  // Decodes one ASCII character as a hexadecimal digit in either case.
  function automatic hex_digit_t hex_decode(logic [CharW-1:0] c);
    hex_digit_t r;
    r.ok  = 1'b0;
    r.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/htwi_in_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Carries one ASCII character request with an end-of-text marker.
// ----------------------------------------------------------------------------
interface htwi_in_if;
  import htwi_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

// ===== hw/rtl/htwi_out_if.sv =====
// ----------------------------------------------------------------------------
// Result word channel
// Carries one 64-bit word of a parsed number with its flags.
// ----------------------------------------------------------------------------
interface htwi_out_if;
  import htwi_pkg::*;

  logic                valid;
  logic                ready;
  logic [WordBits-1:0] value_word;
  logic [WordIdxW-1:0] word_index;
  logic                is_last;
  logic                negative;
  logic                bad_char;
  logic                ended_full;

  modport source (output valid, value_word, word_index, is_last, negative, bad_char,
                  ended_full, input ready);
  modport sink   (input valid, value_word, word_index, is_last, negative, bad_char,
                  ended_full, output ready);
endinterface

// ===== hw/rtl/htwi_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Carries write requests to the word count register.
// ----------------------------------------------------------------------------
interface htwi_cfg_if;
  import htwi_pkg::*;

  logic            valid;
  logic            ready;
  logic [CfgW-1:0] words_in_use;

  modport source (output valid, words_in_use, input ready);
  modport sink   (input valid, words_in_use, output ready);
endinterface

// ===== hw/rtl/hex_text_to_wide_integer_top.sv =====
// ----------------------------------------------------------------------------
// Hex text to wide integer parser
// Parses ASCII hexadecimal text into a wide sign-magnitude integer and
// delivers it as 64-bit words, least significant word first.
//
//   Channel | Dir | Payload                                    | Per request
//   in_ch   | in  | char_code, end_of_input                    | one character
//   out_ch  | out | value_word, word_index, is_last, flags     | one word
//   cfg_ch  | in  | words_in_use                               | one write
//
// Ordinary characters are taken back to back. A terminator, or the digit
// that fills the capacity, ends a number and moves it into the output
// buffer, which then drains one word per cycle while the receiver is
// ready. The buffer is free again once its last word has been taken.
// A number-ending request stalls until the buffer is free again.
// Reset sets words_in_use to 4 and clears the parser; no clearing pass.
// ----------------------------------------------------------------------------
module hex_text_to_wide_integer_top #(
  parameter int MAX_WORDS = htwi_pkg::MaxWordsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  htwi_in_if.sink       in_ch,
  htwi_out_if.source    out_ch,
  htwi_cfg_if.sink      cfg_ch
);
  import htwi_pkg::*;

  `include "assert_macros.svh"

  localparam int MagW    = MAX_WORDS * WordBits;
  localparam int CntW    = $clog2(MAX_WORDS * DigitsPerWord + 1);
  localparam int IdxW    = ($clog2(MAX_WORDS) > WordIdxW) ? $clog2(MAX_WORDS) : WordIdxW;
  localparam int CmpW    = (CntW > 7) ? CntW : 7;
  localparam int UsedCap = (MAX_WORDS > 7) ? 7 : MAX_WORDS;
  localparam int MaxCap  = MAX_WORDS * DigitsPerWord;

  // Configuration register. Writes are to be issued only while the block is idle;
  // the block itself does not enforce this. The register is always ready.
  logic [CfgW-1:0] words_in_use_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_in_use_q <= WordsInUseRst;
    end else if (cfg_ch.valid) begin
      words_in_use_q <= cfg_ch.words_in_use;
    end
  end

  // Effective word count: zero acts as one, anything above the storage
  // acts as the full storage.
  logic [CfgW-1:0] used;
  logic [6:0]      cap;

  always_comb begin
    if (words_in_use_q == '0) begin
      used = CfgW'(1);
    end else if (words_in_use_q > CfgW'(UsedCap)) begin
      used = CfgW'(UsedCap);
    end else begin
      used = words_in_use_q;
    end
  end

  assign cap = {used, 4'b0000};

  // Parser state for the number currently being read.
  logic [MagW-1:0] mag_q, mag_d;
  phase_e          phase_q, phase_d;
  logic            minus_q, minus_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;

  // Output buffer holding the number that is being delivered. It shifts
  // down one word per delivered request, so the head word is always word 0.
  logic [WordBits-1:0] buf_q [MAX_WORDS];
  logic [IdxW-1:0]     idx_q, last_idx_q;
  logic                busy_q, neg_q, bad_q, full_q;

  hex_digit_t      dig;
  logic            term, take, full_now, ends_number, in_acc, out_acc;
  logic [CntW-1:0] cnt_inc;
  logic [MagW-1:0] mag_shift, mag_snap;
  logic            nonzero;

  assign dig       = hex_decode(in_ch.char_code);
  assign term      = in_ch.end_of_input || (in_ch.char_code == ChLf) ||
                     (in_ch.char_code == ChNul);
  assign cnt_inc   = cnt_q + 1'b1;
  assign mag_shift = {mag_q[MagW-5:0], dig.val};

  // Grammar: optional minus, optional 0x prefix, leading zeros skipped,
  // then significant digits. Anything out of place only raises the error.
  always_comb begin
    phase_d = phase_q;
    minus_d = minus_q;
    err_d   = err_q;
    take    = 1'b0;
    unique case (phase_q)
      PH_START: begin
        if (in_ch.char_code == ChMinus) begin
          minus_d = 1'b1;
          phase_d = PH_SIGNED;
        end else if (dig.ok && dig.val == 4'h0) begin
          phase_d = PH_ZERO1;
        end else if (dig.ok) begin
          take = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      PH_SIGNED: begin
        if (dig.ok && dig.val == 4'h0) begin
          phase_d = PH_ZERO1;
        end else if (dig.ok) begin
          take = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      PH_ZERO1: begin
        if (in_ch.char_code == ChLowX || in_ch.char_code == ChUpX ||
            (dig.ok && dig.val == 4'h0)) begin
          phase_d = PH_LEAD;
        end else if (dig.ok) begin
          take = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      PH_LEAD: begin
        if (dig.ok && dig.val != 4'h0) begin
          take = 1'b1;
        end else if (!dig.ok) begin
          err_d = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (dig.ok) begin
          take = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      default: begin
        phase_d = PH_START;
      end
    endcase
    if (take) begin
      phase_d = PH_DIGITS;
    end
  end

  assign full_now    = !term && take && (CmpW'(cnt_inc) >= CmpW'(cap));
  assign ends_number = term || full_now;

  // A number-ending request waits until the buffer is free; every other
  // character passes straight through.
  assign in_ch.ready = !ends_number || !busy_q;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  assign mag_snap = full_now ? mag_shift : mag_q;

  // Only words that are delivered count toward the sign decision.
  always_comb begin
    nonzero = 1'b0;
    for (int k = 0; k < MAX_WORDS; k++) begin
      if (k < int'(used)) begin
        nonzero = nonzero || (mag_snap[k*WordBits +: WordBits] != '0);
      end
    end
  end

  always_comb begin
    mag_d = mag_q;
    cnt_d = cnt_q;
    if (ends_number) begin
      mag_d = '0;
      cnt_d = '0;
    end else if (take) begin
      mag_d = mag_shift;
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      phase_q <= PH_START;
      minus_q <= 1'b0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else if (in_acc) begin
      mag_q <= mag_d;
      cnt_q <= cnt_d;
      if (ends_number) begin
        phase_q <= PH_START;
        minus_q <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        minus_q <= minus_d;
        err_q   <= err_d;
      end
    end
  end

  // Output buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_acc && ends_number) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_acc) begin
      busy_q <= (idx_q != last_idx_q);
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ends_number) begin
      for (int k = 0; k < MAX_WORDS; k++) begin
        buf_q[k] <= mag_snap[k*WordBits +: WordBits];
      end
      last_idx_q <= IdxW'(used - 1'b1);
      neg_q      <= minus_q && nonzero;
      bad_q      <= err_q;
      full_q     <= full_now;
    end else if (out_acc) begin
      for (int k = 0; k < MAX_WORDS - 1; k++) begin
        buf_q[k] <= buf_q[k+1];
      end
    end
  end

  assign out_ch.valid      = busy_q;
  assign out_ch.value_word = buf_q[0];
  assign out_ch.word_index = idx_q[WordIdxW-1:0];
  assign out_ch.is_last    = (idx_q == last_idx_q);
  assign out_ch.negative   = neg_q;
  assign out_ch.bad_char   = bad_q;
  assign out_ch.ended_full = full_q;

  // A number is only handed to the buffer when the buffer is empty.
  `ASSERT_RST(a_load_when_free, (in_acc && ends_number) |-> !busy_q,
              "number loaded while the output buffer was busy")
  // A finished number starts delivery at word zero in the next cycle.
  `ASSERT_RST(a_start_word0, (in_acc && ends_number) |=> (busy_q && idx_q == '0),
              "delivery did not start at word zero")
  // Delivery never runs past the last word of the number.
  `ASSERT_RST(a_idx_bound, busy_q |-> (idx_q <= last_idx_q),
              "word index ran past the last word")
  // The digit count stays below the largest capacity.
  `ASSERT_ALWAYS(a_cnt_bound, (CmpW'(cnt_q) < CmpW'(MaxCap)) || !rst_ni,
                 "digit count reached the storage capacity")

endmodule
